### rtl/core/sirf_pkg.sv
// Shared types, constants and address mapping for the square picture rotate/flip block.
package sirf_pkg;

  localparam int MAX_SIDE   = 8;
  localparam int PIXEL_BITS = 8;

  localparam int IDX_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int CELLS     = 1 << ADDR_W;
  localparam int SIZE_W    = 4;
  localparam int PIX_IN_W  = 8;
  localparam int PIX_OUT_W = 8;
  localparam int KIND_W    = 2;
  localparam int OP_W      = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_XFORM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [OP_W-1:0] OP_ROT_CW  = 2'd0;
  localparam logic [OP_W-1:0] OP_ROT_CCW = 2'd1;
  localparam logic [OP_W-1:0] OP_FLIP_V  = 2'd2;
  localparam logic [OP_W-1:0] OP_FLIP_H  = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;

  // controller -> datapath
  typedef struct packed {
    logic  xf_rd;   // read one source pixel of the sweep
    addr_t xf_dst;  // destination cell of that read
    logic  flip;    // swap active bank after the last copy
  } sirf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_take; // pending read slot free at this edge
    logic rd_pend;  // a read result is still in the RAM output
  } sirf_stat_t;

  // Clamp the size register to 1..MAX_SIDE.
  function automatic logic [SIZE_W-1:0] active_side(input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] n;
    begin
      n = sz;
      if (n == '0) n = SIZE_W'(1);
      if (n > SIZE_W'(MAX_SIDE)) n = SIZE_W'(MAX_SIDE);
      return n;
    end
  endfunction

  // Source cell that lands at dst; cells outside the active square copy over.
  function automatic addr_t src_addr(input logic [OP_W-1:0] op,
                                     input logic [SIZE_W-1:0] n,
                                     input addr_t dst);
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    logic [SIZE_W-1:0] rn;
    logic [SIZE_W-1:0] cn;
    logic [IDX_W-1:0]  sr;
    logic [IDX_W-1:0]  sc;
    begin
      r  = dst[ADDR_W-1:IDX_W];
      c  = dst[IDX_W-1:0];
      rn = n - SIZE_W'(1) - SIZE_W'(r);
      cn = n - SIZE_W'(1) - SIZE_W'(c);
      sr = r;
      sc = c;
      unique case (op)
        OP_ROT_CW: begin
          sr = cn[IDX_W-1:0];
          sc = r;
        end
        OP_ROT_CCW: begin
          sr = c;
          sc = rn[IDX_W-1:0];
        end
        OP_FLIP_V: begin
          sr = rn[IDX_W-1:0];
        end
        OP_FLIP_H: begin
          sc = cn[IDX_W-1:0];
        end
        default: begin
          sr = r;
          sc = c;
        end
      endcase
      if ((SIZE_W'(r) < n) && (SIZE_W'(c) < n)) begin
        return {sr, sc};
      end
      return dst;
    end
  endfunction

endpackage

### rtl/core/sirf_chan_if.sv
// Handshake channel interfaces: command items in, read results out.
interface sirf_in_if;
  logic                           valid;
  logic                           ready;
  logic [sirf_pkg::KIND_W-1:0]    kind;
  logic [sirf_pkg::IDX_W-1:0]     row;
  logic [sirf_pkg::IDX_W-1:0]     col;
  logic [sirf_pkg::PIX_IN_W-1:0]  pixel_in;
  logic [sirf_pkg::OP_W-1:0]      operation;

  modport source (output valid, kind, row, col, pixel_in, operation, input ready);
  modport sink   (input valid, kind, row, col, pixel_in, operation, output ready);
endinterface

interface sirf_out_if;
  logic                           valid;
  logic                           ready;
  logic [sirf_pkg::PIX_OUT_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

### rtl/core/sirf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module sirf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/sirf_ctrl.sv
// Controller: takes items while idle and sequences the whole-picture copy sweep.
module sirf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sirf_pkg::KIND_W-1:0] in_kind,
  input  sirf_pkg::sirf_stat_t        stat,
  output logic                        in_ready,
  output sirf_pkg::sirf_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t          state_r;
  sirf_pkg::addr_t cnt_r;
  logic            fire;

  assign in_ready = (state_r == ST_IDLE) && stat.can_take;
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.xf_dst = cnt_r;
    cmd.xf_rd  = (state_r == ST_SWEEP) && !stat.rd_pend;
    cmd.flip   = (state_r == ST_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (fire && (in_kind == sirf_pkg::KIND_XFORM)) begin
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          // wait out an earlier read still parked in the RAM output
          if (!stat.rd_pend) begin
            cnt_r <= cnt_r + sirf_pkg::ADDR_W'(1);
            if (cnt_r == sirf_pkg::ADDR_W'(sirf_pkg::CELLS - 1)) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/sirf_dp.sv
// Datapath: size register, two picture banks, copy pipe, read result register.
module sirf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sirf_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                           in_fire,
  input  logic [sirf_pkg::KIND_W-1:0]    in_kind,
  input  logic [sirf_pkg::IDX_W-1:0]     in_row,
  input  logic [sirf_pkg::IDX_W-1:0]     in_col,
  input  logic [sirf_pkg::PIX_IN_W-1:0]  in_pixel,
  input  logic [sirf_pkg::OP_W-1:0]      in_op,
  input  sirf_pkg::sirf_cmd_t            cmd,
  output sirf_pkg::sirf_stat_t           stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sirf_pkg::PIX_OUT_W-1:0] out_pixel
);

  localparam int PB = sirf_pkg::PIXEL_BITS;

  logic [sirf_pkg::SIZE_W-1:0]    size_r;
  logic [sirf_pkg::SIZE_W-1:0]    n_side;
  logic                           bank_r;
  logic [sirf_pkg::OP_W-1:0]      op_r;
  logic                           xf_wr_r;
  sirf_pkg::addr_t                xf_waddr_r;
  logic                           rd_pend_r;
  logic                           rd_in_square_r;
  logic                           out_valid_r;
  logic [sirf_pkg::PIX_OUT_W-1:0] out_pix_r;

  logic                           in_square;
  logic                           usr_we;
  logic                           usr_re;
  logic                           pend_move;
  sirf_pkg::addr_t                usr_addr;
  sirf_pkg::addr_t                raddr;
  logic                           re;
  logic                           we0;
  logic                           we1;
  sirf_pkg::addr_t                waddr;
  logic [PB-1:0]                  wdata;
  logic [PB-1:0]                  rdata0;
  logic [PB-1:0]                  rdata1;
  logic [PB-1:0]                  rdata;

  assign n_side    = sirf_pkg::active_side(size_r);
  assign in_square = (sirf_pkg::SIZE_W'(in_row) < n_side) &&
                     (sirf_pkg::SIZE_W'(in_col) < n_side);
  assign usr_addr  = {in_row, in_col};
  assign usr_we    = in_fire && (in_kind == sirf_pkg::KIND_WRITE) && in_square;
  assign usr_re    = in_fire && (in_kind == sirf_pkg::KIND_READ);

  // reads always come from the active bank
  assign re    = usr_re || cmd.xf_rd;
  assign raddr = cmd.xf_rd ? sirf_pkg::src_addr(op_r, n_side, cmd.xf_dst) : usr_addr;
  assign rdata = bank_r ? rdata1 : rdata0;

  // user writes hit the active bank, sweep copies fill the other one
  assign we0   = (usr_we && !bank_r) || (xf_wr_r && bank_r);
  assign we1   = (usr_we && bank_r) || (xf_wr_r && !bank_r);
  assign waddr = xf_wr_r ? xf_waddr_r : usr_addr;
  assign wdata = xf_wr_r ? rdata : PB'(in_pixel);

  sirf_ram #(.WIDTH(PB), .DEPTH(sirf_pkg::CELLS)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata0)
  );

  sirf_ram #(.WIDTH(PB), .DEPTH(sirf_pkg::CELLS)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata1)
  );

  // parked read result moves into the output register when it is free
  assign pend_move     = rd_pend_r && (!out_valid_r || out_ready);
  assign stat.can_take = !rd_pend_r || pend_move;
  assign stat.rd_pend  = rd_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= sirf_pkg::SIZE_RESET;
      bank_r      <= 1'b0;
      xf_wr_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (cmd.flip) begin
        bank_r <= !bank_r;
      end
      xf_wr_r <= cmd.xf_rd;
      if (usr_re) begin
        rd_pend_r <= 1'b1;
      end else if (pend_move) begin
        rd_pend_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    xf_waddr_r <= cmd.xf_dst;
    if (in_fire && (in_kind == sirf_pkg::KIND_XFORM)) begin
      op_r <= in_op;
    end
    if (usr_re) begin
      rd_in_square_r <= in_square;
    end
    if (pend_move) begin
      out_pix_r <= rd_in_square_r ? sirf_pkg::PIX_OUT_W'(rdata) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pix_r;

endmodule

### rtl/core/square_image_rotate_flip_top.sv
// Top level of the square picture store with in-place rotate and mirror.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        kind, row, col, pixel_in, operation
//   out_ch   out  valid/ready        pixel_out (one per read item)
//   cfg_*    in   cfg_we, no stall   cfg_wdata -> picture_size
//
// Pixel writes and reads transfer one per cycle while no transform runs and out_ch
// keeps up; a read result passes the RAM read register, then the output register.
// A transform copies all 64 cells from the active bank to the spare bank
// through the single RAM read port, one cell per cycle unless a read is parked,
// then swaps banks; in_ch.ready stays low meanwhile. A read result parked in the RAM
// output holds off the transform's own transfer until it moves to out_ch's register.
// Reset clears control state and sets picture_size to 8; the picture banks are
// not cleared. A stalled out_ch holds one result in the output register and one
// in the RAM output register, after which in_ch.ready drops.
module square_image_rotate_flip_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sirf_pkg::SIZE_W-1:0] cfg_wdata,
  sirf_in_if.sink                     in_ch,
  sirf_out_if.source                  out_ch
);

  sirf_pkg::sirf_cmd_t  cmd;
  sirf_pkg::sirf_stat_t stat;
  logic                 in_ready;
  logic                 in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  // sequencer: item intake and transform sweep
  sirf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // storage, address mapping and result path
  sirf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_kind   (in_ch.kind),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_pixel  (in_ch.pixel_in),
    .in_op     (in_ch.operation),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.pixel_out)
  );

endmodule

### tb/square_image_rotate_flip_checker.sv
// Checker for the square picture rotate/flip block: tracks the picture and checks every read.
module square_image_rotate_flip_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sirf_pkg::SIZE_W-1:0] cfg_wdata,
  sirf_in_if                          in_mon,
  sirf_out_if                         out_mon,
  output int                          fail_count,
  output int                          outstanding
);
  import sirf_pkg::*;

  logic [PIXEL_BITS-1:0] picture [CELLS];
  logic [SIZE_W-1:0]     size_reg;
  logic [PIX_OUT_W-1:0]  expected_pixels [$];

  always @(posedge clk) begin
    logic [PIXEL_BITS-1:0] old [CELLS];
    logic [PIX_OUT_W-1:0]  want;
    int                    n;
    int                    row;
    int                    col;
    int                    sr;
    int                    sc;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      expected_pixels.delete();
      outstanding <= 0;
    end else begin
      // result side first; a read accepted now cannot show in this same cycle
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: pixel_out expected none, actual %0h", $time, out_mon.pixel_out);
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pixel_out !== want) begin
            fail_count++;
            $display("%0t: pixel_out expected %0h, actual %0h", $time, want,
                     out_mon.pixel_out);
          end
        end
      end
      if (cfg_we) size_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        // size 0 acts as 1, sizes above the maximum saturate
        n   = (size_reg == '0) ? 1 : (size_reg > MAX_SIDE) ? MAX_SIDE : int'(size_reg);
        row = int'(in_mon.row);
        col = int'(in_mon.col);
        case (in_mon.kind)
          KIND_WRITE: begin
            if (row < n && col < n) picture[row*MAX_SIDE+col] = in_mon.pixel_in[PIXEL_BITS-1:0];
          end
          KIND_READ: begin
            if (row < n && col < n) expected_pixels.push_back(PIX_OUT_W'(picture[row*MAX_SIDE+col]));
            else expected_pixels.push_back('0);
          end
          KIND_XFORM: begin
            // only the active square moves
            old = picture;
            for (int r = 0; r < n; r++) begin
              for (int c = 0; c < n; c++) begin
                case (in_mon.operation)
                  OP_ROT_CW: begin
                    sr = n - 1 - c;
                    sc = r;
                  end
                  OP_ROT_CCW: begin
                    sr = c;
                    sc = n - 1 - r;
                  end
                  OP_FLIP_V: begin
                    sr = n - 1 - r;
                    sc = c;
                  end
                  default: begin
                    sr = r;
                    sc = n - 1 - c;
                  end
                endcase
                picture[r*MAX_SIDE+c] = old[sr*MAX_SIDE+sc];
              end
            end
          end
          default: ;
        endcase
      end
      outstanding <= expected_pixels.size();
    end
  end

endmodule

### tb/square_image_rotate_flip_top_test.sv
// Testbench top for the square picture rotate/flip block: stimulus, flow control and verdict.
module square_image_rotate_flip_top_test;
  import sirf_pkg::*;

  // kind 3 has no meaning; the block must drop it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // a transform holds the block through its copy sweep and bank swap after its transfer
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 90;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int cycles    = 0;
  int snd_idle  = 0;  // percent of cycles the sender skips
  int rcv_idle  = 0;  // percent of cycles the receiver stalls
  int hold_left = 0;  // long receiver stall, counted down by the receiver
  int cur_side  = MAX_SIDE;

  sirf_in_if  in_ch ();
  sirf_out_if out_ch ();

  always #2 clk = ~clk;

  square_image_rotate_flip_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  square_image_rotate_flip_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here in cycles.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // One transfer on in_ch. Valid is left high on return so back-to-back items
  // need no extra assignment in the accepting step.
  task automatic send(input logic [KIND_W-1:0] kind, input int row, input int col,
                      input int pix, input logic [OP_W-1:0] op);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.row       <= row[IDX_W-1:0];
    in_ch.col       <= col[IDX_W-1:0];
    in_ch.pixel_in  <= pix[PIX_IN_W-1:0];
    in_ch.operation <= op;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering, wait for every pending read, then let a transform finish.
  // The first edge lets the checker's count catch the last transfer.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Size register writes only happen with the block idle.
  task automatic set_size(input logic [SIZE_W-1:0] sz);
    drain_results();
    cfg_wdata <= sz;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_side = (sz == '0) ? 1 : (sz > MAX_SIDE) ? MAX_SIDE : int'(sz);
  endtask

  // Mostly coordinates inside the active square; reads dominate so results flow.
  task automatic send_random();
    int               pick;
    int               row;
    int               col;
    logic [OP_W-1:0]  op;
    pick = $urandom_range(99);
    op   = OP_W'($urandom_range(3));
    if ($urandom_range(99) < 80) begin
      row = $urandom_range(cur_side - 1);
      col = $urandom_range(cur_side - 1);
    end else begin
      row = $urandom_range(7);
      col = $urandom_range(7);
    end
    if (pick < 40)      send(KIND_WRITE,  row, col, $urandom_range(255), op);
    else if (pick < 85) send(KIND_READ,   row, col, $urandom_range(255), op);
    else if (pick < 95) send(KIND_XFORM,  row, col, $urandom_range(255), op);
    else                send(KIND_UNUSED, row, col, $urandom_range(255), op);
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_sizes [6];
    phase_sizes = '{4'd8, 4'd1, 4'd6, 4'd3, 4'd12, 4'd2};

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_WRITE;
    in_ch.row       <= '0;
    in_ch.col       <= '0;
    in_ch.pixel_in  <= '0;
    in_ch.operation <= OP_ROT_CW;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every cell at full size, so no later read lands on an unwritten pixel
    // no matter how transforms move things around.
    set_size(4'd8);
    for (int r = 0; r < MAX_SIDE; r++) begin
      for (int c = 0; c < MAX_SIDE; c++) send(KIND_WRITE, r, c, $urandom_range(255), OP_ROT_CW);
    end

    // Directed: corner values, two at the pixel extremes, then each transform.
    send(KIND_WRITE, 0, 0, 8'h00, OP_ROT_CW);
    send(KIND_WRITE, 7, 7, 8'hFF, OP_FLIP_H);
    send(KIND_WRITE, 0, 7, 8'hA5, OP_ROT_CCW);
    send(KIND_WRITE, 7, 0, 8'h5A, OP_FLIP_V);
    send(KIND_READ,  0, 0, 0, OP_ROT_CW);
    send(KIND_READ,  7, 7, 0, OP_ROT_CW);
    send(KIND_XFORM, 0, 0, 0, OP_ROT_CW);
    send(KIND_READ,  0, 0, 0, OP_ROT_CW);
    send(KIND_XFORM, 0, 0, 0, OP_ROT_CCW);
    send(KIND_READ,  0, 7, 0, OP_ROT_CW);
    send(KIND_XFORM, 0, 0, 0, OP_FLIP_V);
    send(KIND_READ,  7, 0, 0, OP_ROT_CW);
    send(KIND_XFORM, 0, 0, 0, OP_FLIP_H);
    send(KIND_READ,  7, 7, 0, OP_ROT_CW);
    // unused kind with every field bit set: dropped, no result
    send(KIND_UNUSED, 7, 7, 8'hFF, OP_FLIP_H);

    // Size zero acts as a 1x1 picture: outside writes dropped, outside reads give 0.
    set_size(4'd0);
    send(KIND_WRITE, 0, 0, 8'h3C, OP_ROT_CW);
    send(KIND_WRITE, 5, 6, 8'hC3, OP_ROT_CW);
    send(KIND_READ,  5, 6, 0, OP_ROT_CW);
    send(KIND_READ,  0, 0, 0, OP_ROT_CW);
    send(KIND_XFORM, 0, 0, 0, OP_ROT_CW);
    send(KIND_READ,  0, 0, 0, OP_ROT_CW);
    // Oversized value saturates; the pixel at (5,6) kept its old value.
    set_size(4'd15);
    send(KIND_READ,  5, 6, 0, OP_ROT_CW);
    // Odd size: rotate leaves the cells past the active square alone.
    set_size(4'd5);
    send(KIND_XFORM, 0, 0, 0, OP_ROT_CW);
    send(KIND_READ,  4, 4, 0, OP_ROT_CW);
    send(KIND_READ,  0, 4, 0, OP_ROT_CW);
    send(KIND_READ,  6, 6, 0, OP_ROT_CW);

    // Backpressure: the receiver holds off while reads keep coming, so both
    // result registers fill and in_ch.ready drops; then the sender pauses
    // until every result has come out.
    hold_left = LONG_HOLD;
    repeat (24) send(KIND_READ, $urandom_range(7), $urandom_range(7), $urandom_range(255),
                     OP_W'($urandom_range(3)));
    drain_results();

    // Random phases: sender idles 29 and receiver 49, then swapped, then none.
    for (int p = 0; p < 6; p++) begin
      snd_idle = (p < 2) ? 29 : (p < 4) ? 49 : 0;
      rcv_idle = (p < 2) ? 49 : (p < 4) ? 29 : 0;
      set_size(phase_sizes[p]);
      repeat (PHASE_ITEMS) send_random();
    end

    drain_results();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### square_image_rotate_flip_top.f
rtl/core/sirf_pkg.sv
rtl/core/sirf_chan_if.sv
rtl/core/sirf_ram.sv
rtl/core/sirf_ctrl.sv
rtl/core/sirf_dp.sv
rtl/core/square_image_rotate_flip_top.sv
tb/square_image_rotate_flip_checker.sv
tb/square_image_rotate_flip_top_test.sv
